// ===== rtl/length_prefixed_xor_frame_receiver_macros.svh =====
// Assertion macros for the frame receiver.
`ifndef LENGTH_PREFIXED_XOR_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_XOR_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH
`define LPXR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpxr assertion failed");
`define LPXR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpxr assertion failed");
`else
`define LPXR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPXR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lpxr_pkg.sv =====
`default_nettype none
package lpxr_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADSUM   = 3'd1,
        ST_TOOLONG  = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        CFG_MAX_LEN      = 1'b0,
        CFG_IDLE_TIMEOUT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    localparam logic [5:0]  MAX_LEN_RESET = 6'd47;
    localparam logic [15:0] TIMEOUT_RESET = 16'd70;
    localparam logic [15:0] IDLE_SAT      = 16'hFFFF;
    localparam logic [8:0]  LEN_OFFSET    = 9'd2;

    // one command from the classifier to the emitter
    typedef struct packed {
        logic       is_emit;
        logic [5:0] len;
        t_status    status;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/lpxr_cmd_fifo.sv =====
`default_nettype none
`include "length_prefixed_xor_frame_receiver_macros.svh"
module lpxr_cmd_fifo
    import lpxr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    `LPXR_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full)
    `LPXR_ASSERT_IMP(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_empty)

endmodule
`default_nettype wire

// ===== rtl/lpxr_front.sv =====
`default_nettype none
`include "length_prefixed_xor_frame_receiver_macros.svh"
module lpxr_front
    import lpxr_pkg::*;
#(
    parameter int STORE_BYTES = 64,
    parameter int AW          = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic          i_operation,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_cfg_valid,
    input  wire logic          i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output logic               o_cmd_push,
    output t_cmd               o_cmd,
    input  wire logic          i_cmd_full,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [7:0]         o_rd_data,
    input  wire logic          i_emit_done
);

    localparam logic [AW-1:0] CNT_LIMIT = AW'(STORE_BYTES - 1);

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_count, n_count;
    logic [7:0]    r_xor, n_xor;
    logic [15:0]   r_idle, n_idle;
    logic [8:0]    r_len, n_len;
    logic          r_emit_pend, n_emit_pend;
    logic [5:0]    r_max_len;
    logic [15:0]   r_timeout;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] cnt_inc;
    logic [15:0]   idle_inc;
    logic [8:0]    len_cur;
    logic          err;
    t_status       err_code;

    assign o_full    = i_cmd_full || r_emit_pend;
    assign accept    = i_push && !o_full;
    assign o_rd_data = r_rd_data;
    assign cnt_inc   = r_count + AW'(1);
    assign idle_inc  = (r_idle == IDLE_SAT) ? r_idle : r_idle + 16'd1;
    assign len_cur   = (r_count == AW'(1)) ? ({1'b0, i_rx_byte} + LEN_OFFSET) : r_len;

    always_comb begin
        n_count     = r_count;
        n_xor       = r_xor;
        n_idle      = r_idle;
        n_len       = r_len;
        n_emit_pend = r_emit_pend && !i_emit_done;
        wr_en       = 1'b0;
        err         = 1'b0;
        err_code    = ST_OK;
        o_cmd_push  = 1'b0;
        o_cmd       = '{is_emit: 1'b0, len: 6'd0, status: ST_OK};
        if (accept) begin
            if (t_op'(i_operation) == OP_TICK) begin
                n_idle = idle_inc;
                if ((r_count != '0) && (idle_inc > r_timeout)) begin
                    err      = 1'b1;
                    err_code = ST_TIMEOUT;
                end
            end else begin
                n_idle  = 16'd0;
                wr_en   = 1'b1;
                n_count = cnt_inc;
                n_xor   = r_xor ^ i_rx_byte;
                n_len   = len_cur;
                if ((cnt_inc > AW'(1)) && (len_cur > {3'b000, r_max_len})) begin
                    err      = 1'b1;
                    err_code = ST_TOOLONG;
                end else if ((cnt_inc > AW'(1)) && (len_cur == 9'(cnt_inc))) begin
                    o_cmd_push  = 1'b1;
                    o_cmd       = '{is_emit: 1'b1, len: len_cur[5:0],
                                    status: (n_xor == 8'd0) ? ST_OK : ST_BADSUM};
                    n_count     = '0;
                    n_xor       = 8'd0;
                    n_emit_pend = 1'b1;
                end else if (cnt_inc == CNT_LIMIT) begin
                    err      = 1'b1;
                    err_code = ST_OVERFLOW;
                end
            end
            if (err) begin
                o_cmd_push = 1'b1;
                o_cmd      = '{is_emit: 1'b0, len: 6'd0, status: err_code};
                n_count    = '0;
                n_xor      = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_xor       <= 8'd0;
            r_idle      <= 16'd0;
            r_emit_pend <= 1'b0;
            r_max_len   <= MAX_LEN_RESET;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_idle      <= n_idle;
            r_emit_pend <= n_emit_pend;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_LEN: begin
                        r_max_len <= i_cfg_data[5:0];
                    end
                    CFG_IDLE_TIMEOUT: begin
                        r_timeout <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count] <= i_rx_byte;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    `LPXR_ASSERT_IMP(a_pend_stalls_input, i_clk, i_rst_n, r_emit_pend, o_full)
    `LPXR_ASSERT_IMP(a_count_in_store, i_clk, i_rst_n, 1'b1, r_count < CNT_LIMIT)

endmodule
`default_nettype wire

// ===== rtl/lpxr_back.sv =====
`default_nettype none
`include "length_prefixed_xor_frame_receiver_macros.svh"
module lpxr_back
    import lpxr_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_empty,
    input  wire t_cmd          i_cmd,
    output logic               o_cmd_pop,
    output logic [AW-1:0]      o_rd_addr,
    input  wire logic [7:0]    i_rd_data,
    output logic               o_emit_done,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_of_frame,
    output logic [2:0]         o_status
);

    localparam int CMPW = (AW > 6) ? AW : 6;

    t_back_state   r_state, n_state;
    logic [AW-1:0] r_k, n_k;
    logic [5:0]    r_clen, n_clen;
    t_status       r_cst, n_cst;
    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_olast;
    t_status       r_ostatus;

    logic          slot_free;
    logic          k_last;
    logic          load;
    logic [7:0]    ld_byte;
    logic          ld_last;
    t_status       ld_status;

    assign slot_free       = !r_ovalid || i_pop;
    assign k_last          = (CMPW'(r_k) + CMPW'(1)) == CMPW'(r_clen);
    assign o_rd_addr       = n_k;
    assign o_empty         = !r_ovalid;
    assign o_frame_byte    = r_obyte;
    assign o_last_of_frame = r_olast;
    assign o_status        = r_ostatus;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && slot_free && i_cmd.is_emit) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (slot_free && k_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        o_emit_done = 1'b0;
        load        = 1'b0;
        ld_byte     = 8'd0;
        ld_last     = 1'b1;
        ld_status   = ST_OK;
        n_k         = r_k;
        n_clen      = r_clen;
        n_cst       = r_cst;
        case (r_state)
            BK_IDLE: begin
                n_k = '0;
                if (!i_cmd_empty && slot_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_emit) begin
                        n_clen = i_cmd.len;
                        n_cst  = i_cmd.status;
                    end else begin
                        load      = 1'b1;
                        ld_status = i_cmd.status;
                    end
                end
            end
            BK_EMIT: begin
                if (slot_free) begin
                    load      = 1'b1;
                    ld_byte   = i_rd_data;
                    ld_last   = k_last;
                    ld_status = r_cst;
                    if (k_last) begin
                        o_emit_done = 1'b1;
                        n_k         = '0;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_k = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_clen <= n_clen;
        r_cst  <= n_cst;
        if (load) begin
            r_obyte   <= ld_byte;
            r_olast   <= ld_last;
            r_ostatus <= ld_status;
        end
    end

    `LPXR_ASSERT_IMP(a_k_in_frame, i_clk, i_rst_n, r_state == BK_EMIT, CMPW'(r_k) < CMPW'(r_clen))
    `LPXR_ASSERT_NXT(a_done_to_idle, i_clk, i_rst_n, o_emit_done, r_state == BK_IDLE)

endmodule
`default_nettype wire

// ===== rtl/length_prefixed_xor_frame_receiver.sv =====
// Output path: an error word passes the command FIFO and the output register; the first
// byte of a frame passes the FIFO, store read and output registers, then one word a cycle
// while the output is free. Input: one item a cycle while o_full is low; after a frame's
// last byte, input holds off until the frame store has been read out (one read port).
// Reset: synchronous, active low; counters, XOR, idle timer and config registers reset.
`default_nettype none
module length_prefixed_xor_frame_receiver
    import lpxr_pkg::*;
#(
    parameter int STORE_BYTES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic        i_operation,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_of_frame,
    output logic [2:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(STORE_BYTES);

    logic          cmd_push;
    t_cmd          cmd_in;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    t_cmd          cmd_out;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          emit_done;

    assign o_cfg_ready = 1'b1;

    lpxr_front #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .i_emit_done (emit_done)
    );

    lpxr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    lpxr_back #(
        .AW (AW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_empty     (cmd_empty),
        .i_cmd           (cmd_out),
        .o_cmd_pop       (cmd_pop),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_emit_done     (emit_done),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_frame_byte    (o_frame_byte),
        .o_last_of_frame (o_last_of_frame),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire
